// File: sv/psp_pkg.sv
// Package for the packet send pacer: field widths, register indexes and
// the constants used to scale a packet length into a time increment.
// No dependencies.
package psp_pkg;

    // Field and register widths
    localparam int RATE_W    = 40;
    localparam int MINW_W    = 20;
    localparam int BYTES_W   = 16;
    localparam int FIELD_W   = 48;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = RATE_W;

    // Default width of the stored time
    localparam int TIME_BITS_DEF = 48;

    // Register reset values
    localparam logic [MINW_W-1:0] MIN_WAIT_RESET = MINW_W'(500);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE_BPS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WAIT_US = CFG_IDX_W'(1);

    // Bits per byte times microseconds per second
    localparam longint BITS_PER_BYTE = 8;
    localparam longint US_PER_S      = 1000000;
    localparam longint SCALE         = BITS_PER_BYTE * US_PER_S;

    // Dividend width: largest length times the scale fits in 39 bits
    localparam int NUM_W = 39;

endpackage

// File: sv/packet_send_pacer.sv
// Packet send pacer top level; depends on psp_pkg.
// Sequence: a disabled or empty packet goes from acceptance straight to the result state; others
// pass through the prep, wait, divide and add states first. One transaction at a time.
// The bit-serial restoring divider turns the length into a time increment
// (one quotient bit per cycle, shared subtractor); a new packet is accepted only when idle.
// Reset: synchronous, active low; clears next-send time, rate and state, loads 500 us min wait.
module packet_send_pacer #(
    parameter int TIME_BITS = psp_pkg::TIME_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [psp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psp_pkg::CFG_DAT_W-1:0]    cfg_wdata,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [psp_pkg::BYTES_W-1:0]      s_packet_bytes,
    input  logic [psp_pkg::FIELD_W-1:0]      s_now_us,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [psp_pkg::FIELD_W-1:0]      m_wait_us,
    output logic                             m_hold
);

    localparam int NUM_W  = psp_pkg::NUM_W;
    localparam int RATE_W = psp_pkg::RATE_W;
    localparam int REM_W  = RATE_W + 1;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int WIDE_W = (TIME_BITS > psp_pkg::FIELD_W) ? TIME_BITS : psp_pkg::FIELD_W;
    localparam int SUM_W  = ((TIME_BITS > NUM_W) ? TIME_BITS : NUM_W) + 1;

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_ADD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [RATE_W-1:0]              rate_reg;
    logic [psp_pkg::MINW_W-1:0]     min_wait_reg;
    logic [TIME_BITS-1:0]           next_send_reg;
    logic [TIME_BITS-1:0]           now_reg;
    logic [psp_pkg::BYTES_W-1:0]    bytes_reg;
    logic [TIME_BITS-1:0]           wait_reg;
    logic                           hold_reg;
    logic [NUM_W-1:0]               quot_reg;
    logic [RATE_W-1:0]              rem_reg;
    logic [CNT_W-1:0]               cnt_reg;

    logic                           accept;
    logic                           bypass;
    logic [TIME_BITS-1:0]           now_masked;
    logic [TIME_BITS-1:0]           wait_calc;
    logic [REM_W-1:0]               trial;
    logic [REM_W-1:0]               diff;
    logic [SUM_W-1:0]               sum;
    logic [WIDE_W-1:0]              wait_wide;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = (state_reg == ST_OUT);
    assign accept     = s_valid && s_ready;
    assign bypass     = (rate_reg == '0) || (s_packet_bytes == '0);
    assign now_masked = TIME_BITS'(WIDE_W'(s_now_us));
    assign wait_calc  = next_send_reg - now_reg;

    // Shared subtractor: one restoring divide step
    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign diff  = trial - REM_W'(rate_reg);

    // Saturating add of the increment to the next-send time
    assign sum = SUM_W'(next_send_reg) + SUM_W'(quot_reg);

    assign wait_wide = WIDE_W'(wait_reg);
    assign m_wait_us = wait_wide[psp_pkg::FIELD_W-1:0];
    assign m_hold    = hold_reg;

    // Sequence one transaction through prep, wait, divide and add, or straight to output when bypassed
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = bypass ? ST_OUT : ST_PREP;
                end
            end
            ST_PREP: state_next = ST_WAIT;
            ST_WAIT: state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:  state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and next-send time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rate_reg      <= '0;
            min_wait_reg  <= psp_pkg::MIN_WAIT_RESET;
            next_send_reg <= '0;
            cnt_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    psp_pkg::REG_RATE_BPS:    rate_reg     <= cfg_wdata[RATE_W-1:0];
                    psp_pkg::REG_MIN_WAIT_US: min_wait_reg <= cfg_wdata[psp_pkg::MINW_W-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_PREP: begin
                    // pull a past send time up to now: idle earns no credit
                    if (next_send_reg < now_reg) begin
                        next_send_reg <= now_reg;
                    end
                    cnt_reg <= '0;
                end
                ST_DIV: cnt_reg <= cnt_reg + CNT_W'(1);
                ST_ADD: begin
                    if (sum > SUM_W'({TIME_BITS{1'b1}})) begin
                        next_send_reg <= '1;
                    end else begin
                        next_send_reg <= sum[TIME_BITS-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    bytes_reg <= s_packet_bytes;
                    now_reg   <= now_masked;
                    wait_reg  <= '0;
                    hold_reg  <= 1'b0;
                end
            end
            ST_PREP: begin
                // dividend: bytes * 8 * 1e6
                quot_reg <= NUM_W'(bytes_reg) * NUM_W'(psp_pkg::SCALE);
                rem_reg  <= '0;
            end
            ST_WAIT: begin
                if (wait_calc >= TIME_BITS'(min_wait_reg)) begin
                    wait_reg <= wait_calc;
                    hold_reg <= 1'b1;
                end
            end
            ST_DIV: begin
                if (!diff[REM_W-1]) begin
                    rem_reg  <= diff[RATE_W-1:0];
                    quot_reg <= {quot_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= trial[RATE_W-1:0];
                    quot_reg <= {quot_reg[NUM_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

endmodule

// File: sv/psp_checker.sv
// Port-level checker for the packet send pacer, bound to the top level.
// Depends on psp_pkg and packet_send_pacer.
module psp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [psp_pkg::BYTES_W-1:0]    s_packet_bytes,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [psp_pkg::FIELD_W-1:0]    m_wait_us,
    input logic                           m_hold
);

    // one transaction in flight: never ready while a result is shown
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while result pending");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_wait_us) && $stable(m_hold))
        else $error("result changed while stalled");

    // a short wait is reported as zero
    a_zero_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hold |-> m_wait_us == '0)
        else $error("nonzero wait without hold");

    // an empty packet gives an immediate zero result
    a_empty_pkt: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_packet_bytes == '0 |=> m_valid && !m_hold && m_wait_us == '0)
        else $error("empty packet not passed at once");

    // reset leaves the block idle
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind packet_send_pacer psp_checker u_psp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_packet_bytes (s_packet_bytes),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_wait_us      (m_wait_us),
    .m_hold         (m_hold)
);
